/* rtl/xkb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xkb_pkg: shared types and constants of the xor distance k-bucket table
// Word layouts, status and command codes, sequencer states, sizes.
// ----------------------------------------------------------------------------
package xkb_pkg;

    // table geometry
    localparam int ID_BITS      = 64;
    localparam int BUCKET_DEPTH = 8;

    // fixed field widths
    localparam int ID_W       = 64;
    localparam int CAP_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int BUCKET_W   = 6;
    localparam int SLOT_OUT_W = 3;

    // derived sizes
    localparam int SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int BKT_AW    = $clog2(ID_BITS);
    localparam int RAM_DEPTH = ID_BITS * BUCKET_DEPTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int NBYTES    = ID_W / 8;
    localparam int BYTE_W    = $clog2(NBYTES);
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_LOCAL_ID   = 1'b0;
    localparam logic REG_BUCKET_CAP = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOCAL    = 2'd3;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] contact_id;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [BUCKET_W-1:0]   bucket_index;
        logic [SLOT_OUT_W-1:0] slot_index;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BIT,
        S_FILL,
        S_DECIDE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    // control from the sequencer to the storage
    typedef struct packed {
        logic              slot_we;
        logic [RAM_AW-1:0] slot_wa;
        logic [RAM_AW-1:0] slot_ra;
        logic              fill_we;
        logic [BKT_AW-1:0] fill_addr;
        logic [FILL_W-1:0] fill_wd;
    } t_store_ctl;

endpackage
`default_nettype wire

/* rtl/xkb_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xkb_store: slot memory and bucket fill counts
// One write and one registered read per cycle on each store; fill counts of
// buckets never written read as zero through per-bucket valid bits.
// ----------------------------------------------------------------------------
module xkb_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire xkb_pkg::t_store_ctl        i_ctl,
    input  wire logic [xkb_pkg::ID_W-1:0]   i_slot_wd,
    output logic      [xkb_pkg::ID_W-1:0]   o_slot_rd,
    output logic      [xkb_pkg::FILL_W-1:0] o_fill_rd
);

    logic [xkb_pkg::ID_W-1:0]   r_slot_mem [xkb_pkg::RAM_DEPTH];
    logic [xkb_pkg::FILL_W-1:0] r_fill_mem [xkb_pkg::ID_BITS];
    logic [xkb_pkg::ID_BITS-1:0] r_fill_vld;
    logic [xkb_pkg::ID_W-1:0]   r_slot_rd;
    logic [xkb_pkg::FILL_W-1:0] r_fill_q;
    logic                       r_fill_v;

    // slot memory, contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_ctl.slot_we) begin
            r_slot_mem[i_ctl.slot_wa] <= i_slot_wd;
        end
        r_slot_rd <= r_slot_mem[i_ctl.slot_ra];
    end

    // fill count memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_we) begin
            r_fill_mem[i_ctl.fill_addr] <= i_ctl.fill_wd;
        end
        r_fill_q <= r_fill_mem[i_ctl.fill_addr];
    end

    // valid bits of the fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
            r_fill_v   <= 1'b0;
        end else begin
            if (i_ctl.fill_we) begin
                r_fill_vld[i_ctl.fill_addr] <= 1'b1;
            end
            r_fill_v <= r_fill_vld[i_ctl.fill_addr];
        end
    end

    assign o_slot_rd = r_slot_rd;
    assign o_fill_rd = r_fill_v ? r_fill_q : '0;

endmodule
`default_nettype wire

/* rtl/xor_distance_kbucket_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// xor_distance_kbucket_table_unit: routing table of contact ids in buckets
// Add or remove a contact id in the bucket picked by its first bit that
// differs from the local id; one result word per command word.
// ----------------------------------------------------------------------------
// One command word at a time; the input stalls until the sequencer is back in
// idle. An id equal to the local id passes the scan, bit and done states; an
// add or a remove on an empty bucket also passes the fill and decide states.
// A remove walks the bucket through the single read port of the slot memory,
// one slot per cycle, and when the id is found, at any slot, moves the later
// slots down one per cycle before the done state. The first differing bit is
// found in two steps, byte then bit. The result sits in an output register;
// the sequencer waits in its done state only while an earlier result word is
// still stalled there.
module xor_distance_kbucket_table_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command words
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire xkb_pkg::t_in_word           i_in_data,
    // result words
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output xkb_pkg::t_out_word               o_out_data,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xkb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [xkb_pkg::PDATA_W-1:0] pwdata,
    output logic      [xkb_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    xkb_pkg::t_state               r_state, n_state;
    logic                          r_cmd;
    logic [xkb_pkg::ID_W-1:0]      r_id;
    logic [xkb_pkg::ID_W-1:0]      r_local_id;
    logic [xkb_pkg::CAP_W-1:0]     r_capacity;
    logic [7:0]                    r_diff_byte, n_diff_byte;
    logic [xkb_pkg::BYTE_W-1:0]    r_byte_idx, n_byte_idx;
    logic                          r_diff_zero, n_diff_zero;
    logic [xkb_pkg::BUCKET_W-1:0]  r_bucket, n_bucket;
    logic [xkb_pkg::FILL_W-1:0]    r_fill, n_fill;
    logic [xkb_pkg::FILL_W-1:0]    r_rd_idx, n_rd_idx;
    logic [xkb_pkg::SLOT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [xkb_pkg::SLOT_W-1:0]    r_wr_idx, n_wr_idx;
    logic [xkb_pkg::SLOT_W-1:0]    r_slot, n_slot;
    logic [xkb_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                          r_out_vld;
    xkb_pkg::t_out_word            r_out;

    logic                          in_accept;
    logic                          out_free;
    logic                          cfg_write;
    logic [xkb_pkg::ID_W-1:0]      diff;
    logic [xkb_pkg::BYTE_W-1:0]    scan_byte;
    logic [2:0]                    scan_bit;
    logic [7:0]                    usable;
    logic                          bucket_full;
    logic [xkb_pkg::RAM_AW-1:0]    base;
    logic [xkb_pkg::FILL_W-1:0]    fill_rd;
    logic [xkb_pkg::ID_W-1:0]      slot_rd;
    logic [xkb_pkg::ID_W-1:0]      slot_wd;
    xkb_pkg::t_store_ctl           ctl;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_id <= '0;
            r_capacity <= xkb_pkg::CAP_RESET;
        end else if (cfg_write) begin
            if (paddr[xkb_pkg::PADDR_W-1:3] == xkb_pkg::REG_LOCAL_ID) begin
                r_local_id <= pwdata;
            end else begin
                r_capacity <= pwdata[xkb_pkg::CAP_W-1:0];
            end
        end
    end

    // register read back
    always_comb begin
        if (paddr[xkb_pkg::PADDR_W-1:3] == xkb_pkg::REG_BUCKET_CAP) begin
            prdata = xkb_pkg::PDATA_W'(r_capacity);
        end else begin
            prdata = r_local_id;
        end
    end
    assign pready = 1'b1;

    // first nonzero byte of the masked distance
    always_comb begin
        diff      = (r_id ^ r_local_id) & xkb_pkg::ID_MASK;
        scan_byte = '0;
        for (int i = xkb_pkg::NBYTES - 1; i >= 0; i--) begin
            if (|diff[8*i +: 8]) begin
                scan_byte = xkb_pkg::BYTE_W'(i);
            end
        end
    end

    // first set bit of the selected byte
    always_comb begin
        scan_bit = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_diff_byte[i]) begin
                scan_bit = 3'(i);
            end
        end
    end

    // slots usable per bucket and bucket base address
    always_comb begin
        if (8'(r_capacity) < 8'(xkb_pkg::BUCKET_DEPTH)) begin
            usable = 8'(r_capacity);
        end else begin
            usable = 8'(xkb_pkg::BUCKET_DEPTH);
        end
        bucket_full = 8'(fill_rd) >= usable;
        base = xkb_pkg::RAM_AW'(32'(r_bucket) * xkb_pkg::BUCKET_DEPTH);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            xkb_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = xkb_pkg::S_SCAN;
                end
            end
            xkb_pkg::S_SCAN: begin
                n_state = xkb_pkg::S_BIT;
            end
            xkb_pkg::S_BIT: begin
                n_state = r_diff_zero ? xkb_pkg::S_DONE : xkb_pkg::S_FILL;
            end
            xkb_pkg::S_FILL: begin
                n_state = xkb_pkg::S_DECIDE;
            end
            xkb_pkg::S_DECIDE: begin
                if (r_cmd == xkb_pkg::CMD_REMOVE && fill_rd != '0) begin
                    n_state = xkb_pkg::S_SEARCH;
                end else begin
                    n_state = xkb_pkg::S_DONE;
                end
            end
            xkb_pkg::S_SEARCH: begin
                if (slot_rd == r_id) begin
                    n_state = xkb_pkg::S_SHIFT;
                end else if (32'(r_cmp_idx) + 1 == 32'(r_fill)) begin
                    n_state = xkb_pkg::S_DONE;
                end
            end
            xkb_pkg::S_SHIFT: begin
                if (32'(r_wr_idx) + 1 >= 32'(r_fill)) begin
                    n_state = xkb_pkg::S_DONE;
                end
            end
            xkb_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = xkb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = xkb_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and storage control
    always_comb begin
        n_diff_byte = r_diff_byte;
        n_byte_idx  = r_byte_idx;
        n_diff_zero = r_diff_zero;
        n_bucket    = r_bucket;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_wr_idx    = r_wr_idx;
        n_slot      = r_slot;
        n_status    = r_status;
        slot_wd     = r_id;
        ctl.slot_we   = 1'b0;
        ctl.slot_wa   = base;
        ctl.slot_ra   = xkb_pkg::RAM_AW'(32'(base) + 32'(r_rd_idx));
        ctl.fill_we   = 1'b0;
        ctl.fill_addr = r_bucket[xkb_pkg::BKT_AW-1:0];
        ctl.fill_wd   = fill_rd;
        case (r_state)
            xkb_pkg::S_SCAN: begin
                n_byte_idx  = scan_byte;
                n_diff_byte = diff[{scan_byte, 3'b000} +: 8];
                n_diff_zero = (diff == '0);
            end
            xkb_pkg::S_BIT: begin
                n_slot   = '0;
                n_rd_idx = '0;
                if (r_diff_zero) begin
                    n_status = xkb_pkg::ST_LOCAL;
                    n_bucket = '0;
                end else begin
                    n_bucket = xkb_pkg::BUCKET_W'({r_byte_idx, scan_bit});
                end
            end
            xkb_pkg::S_DECIDE: begin
                // slot 0 of the bucket is read here for a remove
                n_fill = fill_rd;
                if (r_cmd == xkb_pkg::CMD_ADD) begin
                    if (bucket_full) begin
                        n_status = xkb_pkg::ST_FULL;
                    end else begin
                        n_status    = xkb_pkg::ST_DONE;
                        n_slot      = xkb_pkg::SLOT_W'(fill_rd);
                        ctl.slot_we = 1'b1;
                        ctl.slot_wa = xkb_pkg::RAM_AW'(32'(base) + 32'(fill_rd));
                        ctl.fill_we = 1'b1;
                        ctl.fill_wd = fill_rd + 1'b1;
                    end
                end else if (fill_rd == '0) begin
                    n_status = xkb_pkg::ST_NOTFOUND;
                end else begin
                    n_rd_idx  = xkb_pkg::FILL_W'(1);
                    n_cmp_idx = '0;
                end
            end
            xkb_pkg::S_SEARCH: begin
                // compare one slot per cycle while the next one is read
                n_rd_idx = r_rd_idx + 1'b1;
                if (slot_rd == r_id) begin
                    n_slot   = r_cmp_idx;
                    n_wr_idx = r_cmp_idx;
                end else if (32'(r_cmp_idx) + 1 == 32'(r_fill)) begin
                    n_status = xkb_pkg::ST_NOTFOUND;
                end else begin
                    n_cmp_idx = r_cmp_idx + 1'b1;
                end
            end
            xkb_pkg::S_SHIFT: begin
                // close the gap: slot k takes slot k + 1
                if (32'(r_wr_idx) + 1 < 32'(r_fill)) begin
                    ctl.slot_we = 1'b1;
                    ctl.slot_wa = xkb_pkg::RAM_AW'(32'(base) + 32'(r_wr_idx));
                    slot_wd     = slot_rd;
                    n_wr_idx    = r_wr_idx + 1'b1;
                    n_rd_idx    = r_rd_idx + 1'b1;
                end else begin
                    ctl.fill_we = 1'b1;
                    ctl.fill_wd = r_fill - 1'b1;
                    n_status    = xkb_pkg::ST_DONE;
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xkb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_in_data.cmd;
            r_id  <= i_in_data.contact_id;
        end
        r_diff_byte <= n_diff_byte;
        r_byte_idx  <= n_byte_idx;
        r_diff_zero <= n_diff_zero;
        r_bucket    <= n_bucket;
        r_fill      <= n_fill;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_wr_idx    <= n_wr_idx;
        r_slot      <= n_slot;
        r_status    <= n_status;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == xkb_pkg::S_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == xkb_pkg::S_DONE && out_free) begin
            r_out.status       <= r_status;
            r_out.bucket_index <= r_bucket;
            r_out.slot_index   <= xkb_pkg::SLOT_OUT_W'(32'(r_slot));
        end
    end

    assign o_in_stall  = (r_state != xkb_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    xkb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_slot_wd (slot_wd),
        .o_slot_rd (slot_rd),
        .o_fill_rd (fill_rd)
    );

    // an accepted word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("block not busy after accepting a command word");

    // a local id result names bucket 0 and slot 0
    a_local_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == xkb_pkg::ST_LOCAL) |->
        (o_out_data.bucket_index == '0 && o_out_data.slot_index == '0))
        else $error("local id result with nonzero bucket or slot");

    // a fill count never exceeds the bucket depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.fill_we |-> (32'(ctl.fill_wd) <= xkb_pkg::BUCKET_DEPTH))
        else $error("fill count written above bucket depth");

    // compaction only writes below the old fill of the bucket
    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xkb_pkg::S_SHIFT && ctl.slot_we) |->
        (32'(r_wr_idx) + 1 < 32'(r_fill)))
        else $error("slot move outside the filled part of the bucket");

    // a result word is loaded only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == xkb_pkg::S_DONE))
        else $error("result word without a finished command");

endmodule
`default_nettype wire

/* tb/xkb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xkb_checker: result checker of the xor distance k-bucket table
// Follows register writes and accepted command words, keeps its own copy of
// the bucket table, and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module xkb_checker
    import xkb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire t_in_word            i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire t_out_word           i_out_data,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic [PADDR_W-1:0]  i_paddr,
    input  wire logic [PDATA_W-1:0]  i_pwdata,
    input  wire logic                i_pready,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam logic [PADDR_W-1:0] ADDR_LOCAL_ID   = {REG_LOCAL_ID, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_BUCKET_CAP = {REG_BUCKET_CAP, 3'b000};

    // mirror of the table and its registers
    logic [ID_W-1:0]  mirror_ids [ID_BITS][BUCKET_DEPTH];
    int               mirror_fill [ID_BITS];
    logic [ID_W-1:0]  local_id_q;
    logic [CAP_W-1:0] capacity_q;

    t_out_word pending_replies [$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    // apply one command word to the mirror and return the result it gives
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word       r;
        logic [ID_W-1:0] diff;
        int              b;
        int              fill;
        int              usable;
        int              hit;
        r    = '0;
        diff = (w.contact_id ^ local_id_q) & ID_MASK;
        b    = -1;
        for (int i = ID_BITS - 1; i >= 0; i--) begin
            if (diff[i]) b = i;
        end
        if (b < 0) begin
            r.status = ST_LOCAL;
            return r;
        end
        r.bucket_index = b[BUCKET_W-1:0];
        fill   = mirror_fill[b];
        usable = (capacity_q < BUCKET_DEPTH) ? int'(capacity_q) : BUCKET_DEPTH;
        if (w.cmd == CMD_ADD) begin
            if (fill >= usable) begin
                r.status = ST_FULL;
            end else begin
                mirror_ids[b][fill] = w.contact_id;
                mirror_fill[b]      = fill + 1;
                r.status            = ST_DONE;
                r.slot_index        = fill[SLOT_OUT_W-1:0];
            end
        end else begin
            hit = -1;
            for (int i = fill - 1; i >= 0; i--) begin
                if (mirror_ids[b][i] == w.contact_id) hit = i;
            end
            if (hit < 0) begin
                r.status = ST_NOTFOUND;
            end else begin
                // close the gap
                for (int i = hit; i + 1 < fill; i++) begin
                    mirror_ids[b][i] = mirror_ids[b][i+1];
                end
                mirror_fill[b] = fill - 1;
                r.status       = ST_DONE;
                r.slot_index   = hit[SLOT_OUT_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            local_id_q <= '0;
            capacity_q <= CAP_RESET;
            for (int i = 0; i < ID_BITS; i++) begin
                mirror_fill[i] = 0;
            end
            pending_replies.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_LOCAL_ID) local_id_q <= i_pwdata[ID_W-1:0];
                if (i_paddr == ADDR_BUCKET_CAP) capacity_q <= i_pwdata[CAP_W-1:0];
            end
            // result words belong to older commands, so check them first
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    $error("result word with no command waiting: status %0d bucket %0d slot %0d",
                           i_out_data.status, i_out_data.bucket_index, i_out_data.slot_index);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_data.status);
                        mismatches++;
                    end
                    if (i_out_data.bucket_index !== want.bucket_index) begin
                        $error("bucket_index: expected %0d, actual %0d",
                               want.bucket_index, i_out_data.bucket_index);
                        mismatches++;
                    end
                    if (i_out_data.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, i_out_data.slot_index);
                        mismatches++;
                    end
                end
            end
            // accepted command word
            if (i_in_valid && !i_in_stall) begin
                pending_replies.push_back(apply_command(i_in_data));
            end
        end
        o_pending <= pending_replies.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the xor distance k-bucket table
// Drives directed and random add and remove words under several register
// settings, with bursty input and a changing output stall pattern; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import xkb_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_LOCAL_ID   = {REG_LOCAL_ID, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_BUCKET_CAP = {REG_BUCKET_CAP, 3'b000};
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 212;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    t_in_word           in_data     = '0;
    logic               out_stall   = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;

    logic               in_stall;
    logic               out_valid;
    t_out_word          out_data;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 fail_count;
    int                 pending;

    // stimulus state
    logic [ID_W-1:0]    cur_local = '0;
    logic [ID_W-1:0]    added_ids [$];
    int                 burst_left = 0;

    // receiver stall pattern
    int                 stall_mode = 0;
    int                 stall_hold = 0;
    int unsigned        cycle_cnt  = 0;

    always #2 i_clk = ~i_clk;

    xor_distance_kbucket_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    xkb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // stall pattern changes mode after a random hold
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_hold <= $urandom_range(32, 256);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                out_stall <= (cycle_cnt[3:0] < 4'd5);
            end
        endcase
    end

    function automatic t_in_word make_word(input logic cmd, input logic [ID_W-1:0] id);
        t_in_word w;
        w.cmd        = cmd;
        w.contact_id = id;
        return w;
    endfunction

    // id whose first differing bit from the local id is bit b
    function automatic logic [ID_W-1:0] id_in_bucket(input int b);
        logic [ID_W-1:0] upper;
        upper = {$urandom, $urandom};
        return cur_local ^ (64'd1 << b) ^ (upper << (b + 1));
    endfunction

    // one command word, with random gaps between bursts
    task automatic send_word(input t_in_word w);
        int gap;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // wait until every result word is back and the block has settled
    task automatic drain_results();
        if (in_valid) in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ID_W-1:0] lid, input logic [CAP_W-1:0] cap);
        write_reg(ADDR_LOCAL_ID, lid);
        write_reg(ADDR_BUCKET_CAP, {{(PDATA_W-CAP_W){1'b0}}, cap});
        cur_local = lid;
    endtask

    // random word: mostly adds into a few buckets and removes of known ids
    function automatic t_in_word random_word();
        int              r;
        int              b;
        logic [ID_W-1:0] id;
        t_in_word        w;
        r = $urandom_range(0, 99);
        b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ID_BITS - 1)
                                        : $urandom_range(0, 4);
        id = id_in_bucket(b);
        if (r < 40) begin
            w = make_word(CMD_ADD, id);
            added_ids.push_back(id);
            if (added_ids.size() > 48) void'(added_ids.pop_front());
        end else if (r < 46 && added_ids.size() > 0) begin
            // duplicate of a known id
            w = make_word(CMD_ADD, added_ids[$urandom_range(0, added_ids.size() - 1)]);
        end else if (r < 78 && added_ids.size() > 0) begin
            w = make_word(CMD_REMOVE, added_ids[$urandom_range(0, added_ids.size() - 1)]);
        end else if (r < 86) begin
            w = make_word(CMD_REMOVE, id);
        end else if (r < 94) begin
            w = make_word(1'($urandom_range(0, 1)), {$urandom, $urandom});
        end else begin
            w = make_word(1'($urandom_range(0, 1)), cur_local);
        end
        return w;
    endfunction

    logic [CAP_W-1:0] phase_cap [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd2, 4'd5};

    initial begin
        logic [ID_W-1:0] lid;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed part under the reset settings: local id 0, capacity 8
        send_word(make_word(CMD_ADD, 64'd0));                    // equal to local
        send_word(make_word(CMD_REMOVE, 64'd0));
        send_word(make_word(CMD_ADD, 64'h8000_0000_0000_0000));  // top bucket
        send_word(make_word(CMD_ADD, {ID_W{1'b1}}));             // bucket 0
        send_word(make_word(CMD_ADD, 64'd2));
        send_word(make_word(CMD_ADD, 64'd2));                    // duplicate
        send_word(make_word(CMD_ADD, 64'd6));
        send_word(make_word(CMD_REMOVE, 64'd2));                 // lowest copy
        send_word(make_word(CMD_REMOVE, 64'd2));
        send_word(make_word(CMD_REMOVE, 64'd2));                 // not found
        send_word(make_word(CMD_REMOVE, 64'd6));
        send_word(make_word(CMD_REMOVE, 64'h8000_0000_0000_0000));
        for (int i = 1; i < BUCKET_DEPTH; i++) begin
            send_word(make_word(CMD_ADD, 64'(2 * i + 1)));
        end
        send_word(make_word(CMD_ADD, 64'd17));                   // bucket full
        send_word(make_word(CMD_REMOVE, 64'd7));                 // middle of bucket
        send_word(make_word(CMD_REMOVE, 64'h8000_0000_0000_0001));
        drain_results();

        // zero capacity with an all-ones local id
        set_config({ID_W{1'b1}}, 4'd0);
        send_word(make_word(CMD_ADD, 64'd0));
        send_word(make_word(CMD_ADD, {ID_W{1'b1}}));
        drain_results();

        // capacity lowered below a bucket's fill
        set_config(64'd0, 4'd2);
        send_word(make_word(CMD_ADD, 64'd19));
        send_word(make_word(CMD_REMOVE, 64'd3));
        drain_results();

        // random phases over several settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1:       lid = {ID_W{1'b1}};
                2:       lid = '0;
                4:       lid = 64'h8000_0000_0000_0000;
                default: lid = {$urandom, $urandom};
            endcase
            set_config(lid, phase_cap[p]);
            added_ids.delete();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(random_word());
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
